>>> rtl/core/vc1scs_pkg.sv
// Shared types and constants of the VC-1 start code frame splitter.
`timescale 1ns / 1ps
package vc1scs_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
   } vc1scs_req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  payload_byte;
      logic [15:0] zero_run;
      logic [1:0]  pad_zeros;
      logic [31:0] code_value;
      logic [23:0] code_offset;
      logic [23:0] frame_size;
      logic        last;
   } vc1scs_rsp_type;

   localparam int unsigned MAX_RESULTS = 4;

   typedef struct packed {
      logic [2:0]                       count;
      vc1scs_rsp_type [MAX_RESULTS-1:0] item;
   } vc1scs_bundle_type;

   localparam logic [2:0] KIND_PAYLOAD    = 3'd0;
   localparam logic [2:0] KIND_CODE       = 3'd1;
   localparam logic [2:0] KIND_FRAME_END  = 3'd2;
   localparam logic [2:0] KIND_OVERFLOW   = 3'd3;
   localparam logic [2:0] KIND_CODE_LIMIT = 3'd4;
   localparam logic [2:0] KIND_STREAM_END = 3'd5;

   localparam logic CSR_SPLIT_MODE     = 1'b0;
   localparam logic CSR_FRAME_CAPACITY = 1'b1;

   localparam logic [1:0] MODE_STRIP = 2'd1;
   localparam logic [1:0] MODE_KEEP  = 2'd2;

   localparam logic [23:0] CAPACITY_RESET = 24'h100000;
   localparam logic [23:0] WINDOW_IDLE    = 24'hFFFFFF;
   localparam logic [23:0] WINDOW_CODE    = 24'h000001;
   localparam logic [23:0] CODE_PREFIX    = 24'h010000;

   localparam logic [7:0] BYTE_ONE        = 8'h01;
   localparam logic [7:0] BYTE_EMUL       = 8'h03;
   localparam logic [7:0] BYTE_EMUL_LIMIT = 8'h04;
   localparam logic [7:0] CODE_EOS        = 8'h0A;
   localparam logic [7:0] CODE_SLICE      = 8'h0B;
   localparam logic [7:0] CODE_FIELD      = 8'h0C;
   localparam logic [7:0] CODE_USER_FIRST = 8'h1B;
   localparam logic [7:0] CODE_USER_LAST  = 8'h1F;

   localparam logic [15:0] HOLD_MAX        = 16'hFFFF;
   localparam logic [15:0] ZERO_RUN_FLUSH  = 16'd65533;
   localparam logic [15:0] HOLD_AFTER_FLUSH = 16'd2;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = 2;

endpackage

>>> rtl/core/vc1scs_front.sv
// Front end: configuration registers, byte window, frame state and result bundling.
`timescale 1ns / 1ps
module vc1scs_front #(
   parameter int MAX_START_CODES  = 512,
   parameter int FRAME_COUNT_BITS = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [23:0]                csr_wdata,
   input  logic                       accept,
   input  vc1scs_pkg::vc1scs_req_type req,
   output vc1scs_pkg::vc1scs_bundle_type bundle
);
   import vc1scs_pkg::*;

   localparam int SW  = ((FRAME_COUNT_BITS > 24) ? FRAME_COUNT_BITS : 24) + 2;
   localparam int SCW = $clog2(MAX_START_CODES + 1);

   typedef struct packed {
      logic                             fo;
      logic [SW-1:0]                    fbc;
      logic [SCW-1:0]                   scc;
      logic [2:0]                       n;
      vc1scs_rsp_type [MAX_RESULTS-1:0] item;
   } work_type;

   logic [1:0]                  split_mode_ff, split_mode_in;
   logic [23:0]                 capacity_ff, capacity_in;
   logic [23:0]                 win_ff, win_in;
   logic [15:0]                 hz_ff, hz_in;
   logic                        ep_ff, ep_in;
   logic [FRAME_COUNT_BITS-1:0] fbc_ff, fbc_in;
   logic [SCW-1:0]              scc_ff, scc_in;
   logic                        fo_ff, fo_in;

   logic [SW-1:0] lim;
   logic [SW-1:0] cap_ext;
   logic [SW-1:0] count_max;

   function automatic work_type put_res(input work_type w, input logic [2:0] kind,
                                        input logic [15:0] zr, input logic [7:0] pb,
                                        input logic [1:0] pad, input logic [31:0] code,
                                        input logic [SW-1:0] off, input logic [SW-1:0] size);
      work_type v;
      v = w;
      if (v.n < 3'(MAX_RESULTS)) begin
         v.item[v.n[1:0]].kind         = kind;
         v.item[v.n[1:0]].payload_byte = pb;
         v.item[v.n[1:0]].zero_run     = zr;
         v.item[v.n[1:0]].pad_zeros    = pad;
         v.item[v.n[1:0]].code_value   = code;
         v.item[v.n[1:0]].code_offset  = off[23:0];
         v.item[v.n[1:0]].frame_size   = size[23:0];
         v.item[v.n[1:0]].last         = 1'b0;
         v.n = v.n + 3'd1;
      end
      return v;
   endfunction

   function automatic work_type drop(input work_type w);
      work_type v;
      v = w;
      v.fo  = 1'b0;
      v.fbc = '0;
      v.scc = '0;
      return v;
   endfunction

   function automatic work_type grow(input work_type w, input logic [SW-1:0] amount,
                                     input logic [SW-1:0] limit, output logic ok);
      work_type      v;
      logic [SW-1:0] sum;
      sum = w.fbc + amount;
      if (sum > limit) begin
         v  = drop(put_res(w, KIND_OVERFLOW, '0, '0, '0, '0, '0, w.fbc));
         ok = 1'b0;
      end else begin
         v     = w;
         v.fbc = sum;
         ok    = 1'b1;
      end
      return v;
   endfunction

   function automatic work_type payload(input work_type w, input logic [15:0] zr,
                                        input logic [7:0] pb, input logic [SW-1:0] limit);
      work_type v;
      logic     ok;
      v = w;
      if (w.fo) begin
         v = grow(w, SW'(zr) + SW'(1), limit, ok);
         if (ok) begin
            v = put_res(v, KIND_PAYLOAD, zr, pb, '0, '0, '0, v.fbc);
         end
      end
      return v;
   endfunction

   function automatic work_type close_frame(input work_type w, input logic [15:0] zr,
                                            input logic [SW-1:0] limit);
      work_type v;
      logic     ok;
      v = w;
      if (w.fo) begin
         v = grow(w, SW'(zr), limit, ok);
         if (ok) begin
            v = put_res(v, KIND_FRAME_END, zr, '0, '0, '0, '0, v.fbc);
         end
         v = drop(v);
      end
      return v;
   endfunction

   function automatic work_type record(input work_type w, input logic [15:0] zr,
                                       input logic [1:0] pad, input logic [31:0] code,
                                       input logic [SW-1:0] limit);
      work_type      v;
      logic          ok;
      logic [SW-1:0] off;
      off = w.fbc + SW'(zr) + SW'(pad);
      v   = grow(w, SW'(zr) + SW'(pad) + SW'(4), limit, ok);
      if (ok) begin
         v     = put_res(v, KIND_CODE, zr, '0, pad, code, off, v.fbc);
         v.scc = v.scc + SCW'(1);
      end
      return v;
   endfunction

   assign cap_ext   = SW'(capacity_ff);
   assign count_max = SW'({FRAME_COUNT_BITS{1'b1}});
   assign lim       = (cap_ext < count_max) ? cap_ext : count_max;

   always_comb begin
      work_type    w;
      logic [7:0]  b;
      logic [31:0] code;
      logic [15:0] keep;
      logic [1:0]  pad;
      logic        inframe;
      logic        prefix;

      b    = req.data_byte;
      code = {b, CODE_PREFIX};
      w.fo   = fo_ff;
      w.fbc  = SW'(fbc_ff);
      w.scc  = scc_ff;
      w.n    = '0;
      w.item = '0;
      hz_in  = hz_ff;
      win_in = win_ff;
      ep_in  = ep_ff;
      keep   = '0;
      pad    = '0;
      inframe = (b == CODE_SLICE) || (b == CODE_FIELD) ||
                ((b >= CODE_USER_FIRST) && (b <= CODE_USER_LAST));
      prefix  = (win_ff[15:0] == 16'h0000);

      if (win_ff == WINDOW_CODE) begin
         if ((split_mode_ff == MODE_KEEP) && (hz_ff > 16'd2)) begin
            keep = hz_ff - 16'd2;
         end
         hz_in  = '0;
         win_in = WINDOW_IDLE;
         if (w.fo && inframe) begin
            if (w.scc >= SCW'(MAX_START_CODES)) begin
               w = drop(put_res(w, KIND_CODE_LIMIT, '0, '0, '0, '0, '0, w.fbc));
            end else begin
               if (split_mode_ff == MODE_STRIP) begin
                  pad = 2'd0 - (w.fbc[1:0] + keep[1:0]);
               end
               w = record(w, keep, pad, code, lim);
            end
         end else begin
            w = close_frame(w, keep, lim);
            w.fo  = 1'b1;
            w.fbc = '0;
            w.scc = '0;
            w = record(w, '0, '0, code, lim);
            if (b == CODE_EOS) begin
               w = close_frame(w, '0, lim);
            end
         end
      end else begin
         if (ep_ff) begin
            ep_in = 1'b0;
            if (b >= BYTE_EMUL_LIMIT) begin
               w = payload(w, '0, BYTE_EMUL, lim);
            end
         end
         if (b == 8'h00) begin
            if (hz_ff == HOLD_MAX) begin
               w = payload(w, ZERO_RUN_FLUSH, 8'h00, lim);
               hz_in = HOLD_AFTER_FLUSH;
            end else begin
               hz_in = hz_ff + 16'd1;
            end
         end else if ((b == BYTE_ONE) && prefix) begin
            hz_in = hz_ff;
         end else if ((b == BYTE_EMUL) && (split_mode_ff == MODE_STRIP) && prefix) begin
            if (hz_ff != 16'd0) begin
               w = payload(w, hz_ff - 16'd1, 8'h00, lim);
            end
            hz_in = '0;
            ep_in = 1'b1;
         end else begin
            w = payload(w, hz_ff, b, lim);
            hz_in = '0;
         end
         win_in = {win_ff[15:0], b};
      end

      if (req.end_of_stream) begin
         if (win_in == WINDOW_CODE) begin
            w = payload(w, hz_in, BYTE_ONE, lim);
            hz_in = '0;
         end else if (ep_in) begin
            w = payload(w, hz_in, BYTE_EMUL, lim);
            hz_in = '0;
         end
         w = close_frame(w, hz_in, lim);
         w = put_res(w, KIND_STREAM_END, '0, '0, '0, '0, '0, '0);
         w.fo   = 1'b0;
         w.fbc  = '0;
         w.scc  = '0;
         hz_in  = '0;
         win_in = WINDOW_IDLE;
         ep_in  = 1'b0;
      end

      if (w.n != 3'd0) begin
         w.item[w.n[1:0] - 2'd1].last = 1'b1;
      end

      fo_in  = w.fo;
      fbc_in = w.fbc[FRAME_COUNT_BITS-1:0];
      scc_in = w.scc;
      bundle.count = w.n;
      bundle.item  = w.item;
   end

   always_comb begin
      split_mode_in = split_mode_ff;
      capacity_in   = capacity_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SPLIT_MODE:     split_mode_in = csr_wdata[1:0];
            CSR_FRAME_CAPACITY: capacity_in   = csr_wdata;
            default:            split_mode_in = split_mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         split_mode_ff <= '0;
         capacity_ff   <= CAPACITY_RESET;
         win_ff        <= WINDOW_IDLE;
         hz_ff         <= '0;
         ep_ff         <= 1'b0;
         fbc_ff        <= '0;
         scc_ff        <= '0;
         fo_ff         <= 1'b0;
      end else begin
         split_mode_ff <= split_mode_in;
         capacity_ff   <= capacity_in;
         if (accept) begin
            win_ff <= win_in;
            hz_ff  <= hz_in;
            ep_ff  <= ep_in;
            fbc_ff <= fbc_in;
            scc_ff <= scc_in;
            fo_ff  <= fo_in;
         end
      end
   end

   a_eos_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req.end_of_stream) |=>
         (!fo_ff && (hz_ff == 16'd0) && (win_ff == WINDOW_IDLE) && !ep_ff))
      else $error("state not cleared after end of stream");

   a_last_marked: assert property (@(posedge clock) disable iff (reset)
      (bundle.count != 3'd0) |->
         ($countones({bundle.item[0].last, bundle.item[1].last,
                      bundle.item[2].last, bundle.item[3].last}) == 1))
      else $error("bundle without a single last marker");

endmodule

>>> rtl/core/vc1scs_queue.sv
// Short queue of result bundles between front end and back end.
`timescale 1ns / 1ps
module vc1scs_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  vc1scs_pkg::vc1scs_bundle_type push_data,
   input  logic                          pop,
   output vc1scs_pkg::vc1scs_bundle_type head,
   output logic                          head_valid,
   output logic                          full
);
   import vc1scs_pkg::*;

   vc1scs_bundle_type     data_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;

   assign head       = data_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + (QUEUE_AW+1)'(1);
         2'b01:   count_in = count_ff - (QUEUE_AW+1)'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

endmodule

>>> rtl/core/vc1scs_back.sv
// Back end: unpacks result bundles into single results on the output register.
`timescale 1ns / 1ps
module vc1scs_back (
   input  logic                          clock,
   input  logic                          reset,
   input  vc1scs_pkg::vc1scs_bundle_type head,
   input  logic                          head_valid,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output vc1scs_pkg::vc1scs_rsp_type    rsp_data
);
   import vc1scs_pkg::*;

   logic [1:0]     idx_ff, idx_in;
   logic           rsp_valid_ff, rsp_valid_in;
   vc1scs_rsp_type rsp_data_ff, rsp_data_in;
   logic           load;
   logic           at_end;

   assign load   = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign at_end = ({1'b0, idx_ff} == (head.count - 3'd1));
   assign pop    = load && at_end;

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = head.item[idx_ff];
         idx_in       = at_end ? 2'd0 : idx_ff + 2'd1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_idx_in_bundle: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> ({1'b0, idx_ff} < head.count))
      else $error("unpack index beyond bundle");

endmodule

>>> rtl/core/vc1_start_code_frame_splitter.sv
// Top level of the VC-1 start code frame splitter.
//
// Usage: stream bytes enter on req_ (valid/stall), one byte per request, with
// end_of_stream set on the final byte. Each byte gives zero to four results on
// rsp_ (valid/stall); last marks the final result of a byte. Zero bytes give no
// result while held for start code trimming.
// Path: the first result of a byte passes through the bundle queue and then the
// output register. Throughput: one byte per cycle in while req_stall is low,
// one result per cycle out while rsp_stall is low; a byte with several results
// is unpacked one result at a time. The four entry bundle queue between front
// end and back end sets how far input may run ahead before req_stall rises.
// csr_ writes split_mode (index 0) and frame_capacity (index 1); write only
// while idle.
// Reset: synchronous, clears the queue, output register and frame state, and
// sets split_mode 0 and frame_capacity 1048576. A stalled rsp_ holds its
// result; the queue fills and then req_stall is raised.
`timescale 1ns / 1ps
module vc1_start_code_frame_splitter #(
   parameter int MAX_START_CODES  = 512,
   parameter int FRAME_COUNT_BITS = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [23:0]                csr_wdata,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  vc1scs_pkg::vc1scs_req_type req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output vc1scs_pkg::vc1scs_rsp_type rsp_data
);
   import vc1scs_pkg::*;

   logic              accept;
   logic              push;
   logic              pop;
   logic              full;
   logic              head_valid;
   vc1scs_bundle_type bundle;
   vc1scs_bundle_type head;

   assign req_stall = full;
   assign accept    = req_valid && !full;
   assign push      = accept && (bundle.count != 3'd0);

   vc1scs_front #(
      .MAX_START_CODES  (MAX_START_CODES),
      .FRAME_COUNT_BITS (FRAME_COUNT_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .req       (req_data),
      .bundle    (bundle)
   );

   vc1scs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (bundle),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .full       (full)
   );

   vc1scs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

>>> dv/tb_top.sv
// Self-checking testbench of the VC-1 start code frame splitter.
`timescale 1ns / 1ps
module tb_top;
   import vc1scs_pkg::*;

   localparam int unsigned   CODE_LIMIT    = 512;
   localparam logic [1:0]    MODE_PLAIN    = 2'd0;
   localparam logic [1:0]    MODE_SPARE    = 2'd3;
   localparam logic [7:0]    CODE_FRAME    = 8'h0D;
   localparam logic [7:0]    CODE_ENTRY    = 8'h0E;
   localparam logic [7:0]    CODE_SEQ_HDR  = 8'h0F;
   localparam logic [23:0]   CAPACITY_MAX  = 24'hFFFFFF;

   logic           clock     = 1'b0;
   logic           reset     = 1'b1;
   logic           csr_we    = 1'b0;
   logic           csr_index = 1'b0;
   logic [23:0]    csr_wdata = '0;
   logic           req_valid = 1'b0;
   logic           req_stall;
   vc1scs_req_type req_data  = '0;
   logic           rsp_valid;
   logic           rsp_stall = 1'b0;
   vc1scs_rsp_type rsp_data;

   vc1scs_req_type pending_req[$];
   vc1scs_rsp_type expected_rsp[$];
   vc1scs_rsp_type byte_results[$];
   logic           req_taken = 1'b0;
   int unsigned    send_idle_pct = 0;
   int unsigned    stall_pct = 0;

   logic [1:0]     mode_q;
   logic [23:0]    cap_q;
   logic [23:0]    win;
   logic [15:0]    held;
   bit             emul;
   logic [23:0]    fcount;
   logic [9:0]     ncodes;
   bit             fopen;

   int unsigned    n_bad = 0;
   int unsigned    n_bytes = 0;
   int unsigned    n_results = 0;
   int unsigned    n_codes = 0;
   int unsigned    n_frame_ends = 0;
   int unsigned    n_drops = 0;
   int unsigned    n_writes = 0;

   vc1_start_code_frame_splitter u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic void clear_stream();
      win    = WINDOW_IDLE;
      held   = '0;
      emul   = 1'b0;
      fcount = '0;
      ncodes = '0;
      fopen  = 1'b0;
   endfunction

   function automatic void emit(logic [2:0] kind, int unsigned zr, logic [7:0] pb,
                                logic [1:0] pad, logic [31:0] code, int unsigned off,
                                int unsigned size);
      vc1scs_rsp_type r;
      if (byte_results.size() >= MAX_RESULTS) return;
      r = '0;
      r.kind         = kind;
      r.payload_byte = pb;
      r.zero_run     = zr[15:0];
      r.pad_zeros    = pad;
      r.code_value   = code;
      r.code_offset  = off[23:0];
      r.frame_size   = size[23:0];
      byte_results.push_back(r);
   endfunction

   function automatic void drop_frame();
      fopen  = 1'b0;
      fcount = '0;
      ncodes = '0;
   endfunction

   function automatic bit grow(int unsigned n);
      if (32'(fcount) + n > 32'(cap_q)) begin
         emit(KIND_OVERFLOW, 0, '0, '0, '0, 0, 32'(fcount));
         drop_frame();
         return 1'b0;
      end
      fcount = 24'(32'(fcount) + n);
      return 1'b1;
   endfunction

   function automatic void append_byte(int unsigned zr, logic [7:0] b);
      if (!fopen) return;
      if (grow(zr + 1)) emit(KIND_PAYLOAD, zr, b, '0, '0, 0, 32'(fcount));
   endfunction

   function automatic void close_frame(int unsigned zr);
      if (!fopen) return;
      if (grow(zr)) emit(KIND_FRAME_END, zr, '0, '0, '0, 0, 32'(fcount));
      drop_frame();
   endfunction

   function automatic void record_code(int unsigned zr, logic [1:0] pad, logic [31:0] code);
      int unsigned off;
      off = 32'(fcount) + zr + 32'(pad);
      if (grow(zr + 32'(pad) + 4)) begin
         emit(KIND_CODE, zr, '0, pad, code, off, 32'(fcount));
         ncodes = ncodes + 10'd1;
      end
   endfunction

   function automatic void take_code(logic [7:0] b);
      logic [31:0] code;
      int unsigned extra;
      int unsigned keep;
      logic [1:0]  pad;
      bit          inframe;
      code    = {b, CODE_PREFIX};
      extra   = held > 2 ? 32'(held) - 2 : 0;
      keep    = mode_q == MODE_KEEP ? extra : 0;
      inframe = b == CODE_SLICE || b == CODE_FIELD ||
                (b >= CODE_USER_FIRST && b <= CODE_USER_LAST);
      held = '0;
      win  = WINDOW_IDLE;
      if (fopen && inframe) begin
         if (ncodes >= CODE_LIMIT) begin
            emit(KIND_CODE_LIMIT, 0, '0, '0, '0, 0, 32'(fcount));
            drop_frame();
         end else begin
            pad = '0;
            if (mode_q == MODE_STRIP) pad = 2'd0 - 2'(32'(fcount) + keep);
            record_code(keep, pad, code);
         end
         return;
      end
      close_frame(keep);
      fopen  = 1'b1;
      fcount = '0;
      ncodes = '0;
      record_code(0, '0, code);
      if (b == CODE_EOS) close_frame(0);
   endfunction

   function automatic void split_byte(vc1scs_req_type req);
      logic [7:0] b;
      bit         prefix;
      b = req.data_byte;
      byte_results.delete();
      if (win == WINDOW_CODE) begin
         take_code(b);
      end else begin
         prefix = win[15:0] == '0;
         if (emul) begin
            emul = 1'b0;
            if (b >= BYTE_EMUL_LIMIT) append_byte(0, BYTE_EMUL);
         end
         if (b == '0) begin
            if (held >= HOLD_MAX) begin
               append_byte(32'(ZERO_RUN_FLUSH), '0);
               held = HOLD_AFTER_FLUSH;
            end else begin
               held = held + 16'd1;
            end
         end else if (b == BYTE_ONE && prefix) begin
            // hold: may start a code
         end else if (b == BYTE_EMUL && mode_q == MODE_STRIP && prefix) begin
            if (held > 0) append_byte(32'(held) - 1, '0);
            held = '0;
            emul = 1'b1;
         end else begin
            append_byte(32'(held), b);
            held = '0;
         end
         win = {win[15:0], b};
      end
      if (req.end_of_stream) begin
         if (win == WINDOW_CODE) begin
            append_byte(32'(held), BYTE_ONE);
            held = '0;
         end else if (emul) begin
            append_byte(32'(held), BYTE_EMUL);
            held = '0;
         end
         close_frame(32'(held));
         emit(KIND_STREAM_END, 0, '0, '0, '0, 0, 0);
         clear_stream();
      end
      if (byte_results.size() > 0) byte_results[byte_results.size() - 1].last = 1'b1;
      foreach (byte_results[i]) expected_rsp.push_back(byte_results[i]);
   endfunction

   function automatic void flag_bad(string why, vc1scs_rsp_type want, vc1scs_rsp_type got);
      n_bad++;
      if (n_bad <= 10) begin
         $display("%0t %s: want kind %0d byte %h zeros %0d pad %0d code %h off %0d",
                  $time, why, want.kind, want.payload_byte, want.zero_run,
                  want.pad_zeros, want.code_value, want.code_offset);
         $display("   want size %0d last %0b", want.frame_size, want.last);
         $display("   got kind %0d byte %h zeros %0d pad %0d code %h off %0d",
                  got.kind, got.payload_byte, got.zero_run, got.pad_zeros,
                  got.code_value, got.code_offset);
         $display("   got size %0d last %0b", got.frame_size, got.last);
      end
   endfunction

   always @(posedge clock) begin : track
      vc1scs_rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
         mode_q = MODE_PLAIN;
         cap_q  = CAPACITY_RESET;
         clear_stream();
      end else begin
         req_taken <= req_valid && !req_stall;
         if (csr_we) begin
            if (csr_index == CSR_SPLIT_MODE) mode_q = csr_wdata[1:0];
            else cap_q = csr_wdata;
         end
         if (rsp_valid && !rsp_stall) begin
            n_results++;
            case (rsp_data.kind) inside
               KIND_CODE: n_codes++;
               KIND_FRAME_END: n_frame_ends++;
               KIND_OVERFLOW, KIND_CODE_LIMIT: n_drops++;
               default: ;
            endcase
            if (expected_rsp.size() == 0) begin
               flag_bad("unexpected response", '0, rsp_data);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.kind !== want.kind ||
                   rsp_data.payload_byte !== want.payload_byte ||
                   rsp_data.zero_run !== want.zero_run ||
                   rsp_data.pad_zeros !== want.pad_zeros ||
                   rsp_data.code_value !== want.code_value ||
                   rsp_data.code_offset !== want.code_offset ||
                   rsp_data.frame_size !== want.frame_size || rsp_data.last !== want.last)
                  flag_bad("response mismatch", want, rsp_data);
            end
         end
         if (req_valid && !req_stall) begin
            n_bytes++;
            split_byte(req_data);
         end
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (pending_req.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data  <= pending_req.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= $urandom_range(99) < stall_pct;
      end
   end

   task automatic add_byte(input logic [7:0] b, input bit eos);
      vc1scs_req_type r;
      r.data_byte     = b;
      r.end_of_stream = eos;
      pending_req.push_back(r);
   endtask

   task automatic add_code(input int unsigned zeros, input logic [7:0] b, input bit eos);
      repeat (zeros) add_byte(8'h00, 1'b0);
      add_byte(BYTE_ONE, 1'b0);
      add_byte(b, eos);
   endtask

   task automatic add_random_bytes(input int unsigned n);
      logic [7:0]  seg[$];
      int unsigned added;
      int unsigned pick;
      bit          eos;
      added = 0;
      while (added < n) begin
         seg.delete();
         pick = $urandom_range(99);
         if (pick < 22) begin
            repeat ($urandom_range(3) == 0 ? $urandom_range(5, 2) : 2) seg.push_back(8'h00);
            seg.push_back(BYTE_ONE);
            case ($urandom_range(5))
               0: seg.push_back(CODE_FRAME);
               1: seg.push_back(CODE_ENTRY);
               2: seg.push_back(CODE_SEQ_HDR);
               3: seg.push_back(CODE_EOS);
               default: seg.push_back(8'($urandom));
            endcase
         end else if (pick < 42) begin
            repeat ($urandom_range(3) == 0 ? $urandom_range(5, 2) : 2) seg.push_back(8'h00);
            seg.push_back(BYTE_ONE);
            case ($urandom_range(2))
               0: seg.push_back(CODE_SLICE);
               1: seg.push_back(CODE_FIELD);
               default: seg.push_back(CODE_USER_FIRST + 8'($urandom_range(4)));
            endcase
         end else if (pick < 66) begin
            repeat ($urandom_range(10, 1))
               seg.push_back($urandom_range(3) == 0 ? 8'($urandom_range(4)) : 8'($urandom));
         end else if (pick < 78) begin
            if ($urandom_range(4) != 0) seg.push_back(8'h00);
            seg.push_back(8'h00);
            seg.push_back(BYTE_EMUL);
            seg.push_back($urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(7)));
         end else if (pick < 88) begin
            repeat ($urandom_range(6, 1)) seg.push_back(8'h00);
         end else if (pick < 94) begin
            seg.push_back(8'h00);
            seg.push_back(8'h00);
            seg.push_back(8'($urandom));
         end else begin
            repeat ($urandom_range(4, 1)) seg.push_back(8'($urandom));
         end
         eos = $urandom_range(29) == 0;
         foreach (seg[i]) add_byte(seg[i], eos && i == seg.size() - 1);
         added += seg.size();
      end
   endtask

   task automatic wait_quiet();
      while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [23:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we    = 1'b0;
      n_writes++;
   endtask

   task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
      send_idle_pct = send_pct;
      stall_pct     = recv_pct;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      set_idling(0, 0);
      add_byte(8'hFF, 1'b0);
      add_code(2, CODE_FRAME, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'h80, 1'b0);
      add_code(3, CODE_SLICE, 1'b0);
      add_code(2, CODE_EOS, 1'b0);
      add_code(2, CODE_FRAME, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(BYTE_ONE, 1'b1);
      wait_quiet();

      add_code(2, CODE_FRAME, 1'b0);
      add_byte(8'h55, 1'b0);
      add_code(2, CODE_FRAME, 1'b0);
      add_code(2, CODE_SLICE, 1'b0);
      add_random_bytes(40);
      wait_quiet();

      write_reg(CSR_SPLIT_MODE, 24'(MODE_STRIP));
      write_reg(CSR_FRAME_CAPACITY, CAPACITY_MAX);
      set_idling(52, 0);
      add_random_bytes(40);
      wait_quiet();
      add_random_bytes(40);
      wait_quiet();

      write_reg(CSR_SPLIT_MODE, 24'(MODE_KEEP));
      write_reg(CSR_FRAME_CAPACITY, 24'd48);
      set_idling(0, 52);
      add_random_bytes(80);
      wait_quiet();

      write_reg(CSR_SPLIT_MODE, 24'(MODE_STRIP));
      write_reg(CSR_FRAME_CAPACITY, 24'd0);
      set_idling(11, 11);
      add_random_bytes(40);
      wait_quiet();

      write_reg(CSR_SPLIT_MODE, 24'(MODE_SPARE));
      write_reg(CSR_FRAME_CAPACITY, 24'd200);
      add_random_bytes(60);
      wait_quiet();

      write_reg(CSR_SPLIT_MODE, 24'(MODE_PLAIN));
      write_reg(CSR_FRAME_CAPACITY, CAPACITY_RESET);
      set_idling(0, 0);
      add_random_bytes(30);
      wait_quiet();
      repeat (10) @(posedge clock);

      n_bad += expected_rsp.size();
      $display("Sent %0d stream bytes under %0d register writes, checked %0d responses",
               n_bytes, n_writes, n_results);
      $display("  (%0d code records, %0d frame ends, %0d overflow or code-limit drops)",
               n_codes, n_frame_ends, n_drops);
      if (n_bad == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches", n_bad);
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Timeout with %0d responses outstanding", expected_rsp.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule
